[rtl/zard_pkg.sv]
// Shared types, codes and mapping table for the attribute report decoder.
package zard_pkg;

  localparam int unsigned NumMaps = 5;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNotMapped = 2'd1,
    StInvalid   = 2'd2
  } status_e;

  localparam logic [7:0] TagBool = 8'h10;
  localparam logic [7:0] TagU8   = 8'h20;
  localparam logic [7:0] TagU16  = 8'h21;
  localparam logic [7:0] TagU24  = 8'h22;
  localparam logic [7:0] TagU32  = 8'h23;
  localparam logic [7:0] TagS8   = 8'h28;
  localparam logic [7:0] TagS16  = 8'h29;
  localparam logic [7:0] TagS32  = 8'h2B;
  localparam logic [7:0] TagF32  = 8'h39;

  localparam logic [15:0] BatteryCluster = 16'h0001;

  typedef struct packed {
    logic [15:0] cl;
    logic [15:0] at;
    logic        binary;
    logic        battery;
    logic [12:0] neg_lim;
    logic [13:0] pos_lim;
    logic [6:0]  mul;
  } map_entry_t;

  localparam map_entry_t MapTable [NumMaps] = '{
    '{cl: 16'h0402, at: 16'h0000, binary: 1'b0, battery: 1'b0,
      neg_lim: 13'd4000, pos_lim: 14'd8000, mul: 7'd1},
    '{cl: 16'h0405, at: 16'h0000, binary: 1'b0, battery: 1'b0,
      neg_lim: 13'd0, pos_lim: 14'd10000, mul: 7'd1},
    '{cl: 16'h040D, at: 16'h0000, binary: 1'b0, battery: 1'b0,
      neg_lim: 13'd0, pos_lim: 14'd5000, mul: 7'd100},
    '{cl: 16'h000F, at: 16'h0055, binary: 1'b1, battery: 1'b0,
      neg_lim: 13'd0, pos_lim: 14'd0, mul: 7'd0},
    '{cl: 16'h0001, at: 16'h0021, binary: 1'b0, battery: 1'b1,
      neg_lim: 13'd0, pos_lim: 14'd200, mul: 7'd50}
  };

  typedef struct packed {
    logic        hit;
    logic        binary;
    logic        battery;
    logic [12:0] neg_lim;
    logic [13:0] pos_lim;
    logic [6:0]  mul;
  } map_sel_t;

  typedef struct packed {
    status_e            status;
    logic [63:0]        address;
    logic [15:0]        cluster;
    logic [15:0]        attribute;
    logic [7:0]         type_tag;
    logic signed [19:0] value_centi;
    logic               value_flag;
    logic [7:0]         quality;
    logic [7:0]         battery;
  } result_t;

endpackage

[rtl/zcl_attribute_report_decoder.sv]
// Top level of the attribute report decoder: input register, decode, result register.
//
// Decodes one attribute report per request and returns one result for each. A new request
// can be accepted in every clock cycle unless the output side stalls; an accepted request
// waits in the input register while the mapping lookup and decode feed the result register.
// Both sides use valid/ready; a stalled result holds in the result register while the input
// register can still take one more request, so in_ready_o drops only when both registers
// are full and out_ready_i is low. There is no configuration and no state between requests.
module zcl_attribute_report_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        source_address_i,
  input  logic [15:0]        cluster_i,
  input  logic [15:0]        attribute_i,
  input  logic [7:0]         type_tag_i,
  input  logic [31:0]        payload_bytes_i,
  input  logic [7:0]         payload_len_i,
  input  logic [7:0]         link_quality_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [63:0]        report_address_o,
  output logic [15:0]        report_cluster_o,
  output logic [15:0]        report_attribute_o,
  output logic [7:0]         report_type_o,
  output logic signed [19:0] value_centi_o,
  output logic               value_flag_o,
  output logic [7:0]         report_quality_o,
  output logic [7:0]         battery_percent_o
);

  logic               s1_valid_q, s1_valid_d;
  logic               out_valid_q, out_valid_d;
  logic [63:0]        addr_q;
  logic [15:0]        cluster_q;
  logic [15:0]        attr_q;
  logic [7:0]         tag_q;
  logic [31:0]        payload_q;
  logic [7:0]         len_q;
  logic [7:0]         lqi_q;
  logic               out_adv;
  zard_pkg::map_sel_t map_sel;
  zard_pkg::result_t  res_d;
  zard_pkg::result_t  res_q;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_adv;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (in_ready_o) s1_valid_d = in_valid_i;
    if (out_adv) out_valid_d = s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // capture the request
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      addr_q    <= source_address_i;
      cluster_q <= cluster_i;
      attr_q    <= attribute_i;
      tag_q     <= type_tag_i;
      payload_q <= payload_bytes_i;
      len_q     <= payload_len_i;
      lqi_q     <= link_quality_i;
    end
  end

  zard_match u_match (
    .cluster_i   (cluster_q),
    .attribute_i (attr_q),
    .map_o       (map_sel)
  );

  zard_decode u_decode (
    .map_i            (map_sel),
    .source_address_i (addr_q),
    .cluster_i        (cluster_q),
    .attribute_i      (attr_q),
    .type_tag_i       (tag_q),
    .payload_bytes_i  (payload_q),
    .payload_len_i    (len_q),
    .link_quality_i   (lqi_q),
    .res_o            (res_d)
  );

  // load the result only when the output side can move
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = res_q.status;
  assign report_address_o   = res_q.address;
  assign report_cluster_o   = res_q.cluster;
  assign report_attribute_o = res_q.attribute;
  assign report_type_o      = res_q.type_tag;
  assign value_centi_o      = res_q.value_centi;
  assign value_flag_o       = res_q.value_flag;
  assign report_quality_o   = res_q.quality;
  assign battery_percent_o  = res_q.battery;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while pipeline not full");

  a_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != zard_pkg::StOk) |->
      (report_address_o == 64'd0 && value_centi_o == 20'sd0 &&
       battery_percent_o == 8'd0 && value_flag_o == 1'b0))
    else $error("non-ok result carries data");

  a_flag_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_flag_o) |-> (value_centi_o == 20'sd100))
    else $error("active binary flag without value 100");

  a_battery_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == zard_pkg::StOk && battery_percent_o != 8'hFF) |->
      (battery_percent_o <= 8'd100 && report_cluster_o == zard_pkg::BatteryCluster))
    else $error("battery percent out of range or on a non-battery report");
`endif

endmodule

[rtl/zard_match.sv]
// Lookup of the cluster/attribute pair in the fixed mapping table.
module zard_match (
  input  logic [15:0]         cluster_i,
  input  logic [15:0]         attribute_i,
  output zard_pkg::map_sel_t  map_o
);

  always_comb begin
    map_o = '0;
    // scan backward so the first matching entry wins
    for (int i = zard_pkg::NumMaps - 1; i >= 0; i--) begin
      if (zard_pkg::MapTable[i].cl == cluster_i && zard_pkg::MapTable[i].at == attribute_i) begin
        map_o.hit     = 1'b1;
        map_o.binary  = zard_pkg::MapTable[i].binary;
        map_o.battery = zard_pkg::MapTable[i].battery;
        map_o.neg_lim = zard_pkg::MapTable[i].neg_lim;
        map_o.pos_lim = zard_pkg::MapTable[i].pos_lim;
        map_o.mul     = zard_pkg::MapTable[i].mul;
      end
    end
  end

endmodule

[rtl/zard_decode.sv]
// Payload decode, range check, scaling and rounding of one report.
module zard_decode (
  input  zard_pkg::map_sel_t  map_i,
  input  logic [63:0]         source_address_i,
  input  logic [15:0]         cluster_i,
  input  logic [15:0]         attribute_i,
  input  logic [7:0]          type_tag_i,
  input  logic [31:0]         payload_bytes_i,
  input  logic [7:0]          payload_len_i,
  input  logic [7:0]          link_quality_i,
  output zard_pkg::result_t   res_o
);

  // round p / 2^s to nearest, ties up; p stays below 2^31
  function automatic logic [30:0] rnd_shift(input logic [30:0] p, input logic [7:0] s);
    logic [31:0] half;
    logic [31:0] sum;
    logic [30:0] q;
    half = 32'd0;
    sum  = 32'd0;
    if (s == 8'd0) begin
      q = p;
    end else if (s > 8'd31) begin
      q = '0;
    end else begin
      half = 32'd1 << (s[4:0] - 5'd1);
      sum  = {1'b0, p} + half;
      q    = 31'(sum >> s[4:0]);
    end
    return q;
  endfunction

  logic [2:0]         w;
  logic               neg;
  logic               huge;
  logic               nan;
  logic [32:0]        mag;
  logic [7:0]         sh;
  logic [7:0]         ex;
  logic [22:0]        fr;
  logic [32:0]        ip;
  logic [32:0]        mask;
  logic               frac;
  logic [13:0]        lim;
  logic               out_of_range;
  logic [30:0]        prod;
  logic [30:0]        cmag;
  logic [30:0]        bmag;
  zard_pkg::status_e  st;
  logic               flag;
  logic [19:0]        centi;
  logic [7:0]         batt;

  assign ex = payload_bytes_i[30:23];
  assign fr = payload_bytes_i[22:0];

  always_comb begin
    w    = 3'd0;
    neg  = 1'b0;
    huge = 1'b0;
    nan  = 1'b0;
    mag  = '0;
    sh   = 8'd0;
    unique case (type_tag_i) inside
      zard_pkg::TagBool, zard_pkg::TagU8: begin
        w   = 3'd1;
        mag = {25'd0, payload_bytes_i[7:0]};
      end
      zard_pkg::TagU16: begin
        w   = 3'd2;
        mag = {17'd0, payload_bytes_i[15:0]};
      end
      zard_pkg::TagU24: begin
        w   = 3'd3;
        mag = {9'd0, payload_bytes_i[23:0]};
      end
      zard_pkg::TagU32: begin
        w   = 3'd4;
        mag = {1'b0, payload_bytes_i};
      end
      zard_pkg::TagS8: begin
        w   = 3'd1;
        neg = payload_bytes_i[7];
        mag = {25'd0, payload_bytes_i[7:0]};
        if (neg) mag = 33'h100 - mag;
      end
      zard_pkg::TagS16: begin
        w   = 3'd2;
        neg = payload_bytes_i[15];
        mag = {17'd0, payload_bytes_i[15:0]};
        if (neg) mag = 33'h1_0000 - mag;
      end
      zard_pkg::TagS32: begin
        w   = 3'd4;
        neg = payload_bytes_i[31];
        mag = {1'b0, payload_bytes_i};
        if (neg) mag = 33'h1_0000_0000 - mag;
      end
      zard_pkg::TagF32: begin
        w   = 3'd4;
        neg = payload_bytes_i[31];
        if (ex == 8'hFF) begin
          if (fr != 23'd0) begin
            nan = 1'b1;
          end else begin
            huge = 1'b1;
            mag  = 33'd1;
          end
        end else if (ex == 8'd0) begin
          mag = {10'd0, fr};
          sh  = 8'd149;
        end else begin
          mag = {9'd0, 1'b1, fr};
          // magnitude of 2^23 or more is far beyond any limit
          if (ex >= 8'd150) huge = 1'b1;
          else sh = 8'd150 - ex;
        end
      end
      default: begin
        w = 3'd0;
      end
    endcase
  end

  // integer part and fraction flag of mag / 2^sh
  always_comb begin
    if (sh >= 8'd33) begin
      ip   = '0;
      mask = '1;
    end else begin
      ip   = mag >> sh[5:0];
      mask = (33'd1 << sh[5:0]) - 33'd1;
    end
    frac         = |(mag & mask);
    lim          = neg ? {1'b0, map_i.neg_lim} : map_i.pos_lim;
    out_of_range = (ip > {19'd0, lim}) || (ip == {19'd0, lim} && frac);
  end

  // a value that passes the check fits in 24 bits, so drop the upper bits
  assign prod = 31'({7'd0, mag[23:0]} * {24'd0, map_i.mul});
  assign cmag = rnd_shift(prod, sh);
  assign bmag = rnd_shift({7'd0, mag[23:0]}, sh + 8'd1);

  always_comb begin
    st    = zard_pkg::StOk;
    flag  = 1'b0;
    centi = 20'd0;
    batt  = 8'hFF;
    if (!map_i.hit) begin
      st = zard_pkg::StNotMapped;
    end else if (w == 3'd0 || payload_len_i < {5'd0, w} || nan) begin
      st = zard_pkg::StInvalid;
    end else if (map_i.binary) begin
      flag  = huge || (mag != 33'd0);
      centi = flag ? 20'd100 : 20'd0;
    end else if (huge || out_of_range) begin
      st = zard_pkg::StInvalid;
    end else begin
      centi = neg ? (20'd0 - cmag[19:0]) : cmag[19:0];
      if (map_i.battery) batt = bmag[7:0];
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = st;
    if (st == zard_pkg::StOk) begin
      res_o.address     = source_address_i;
      res_o.cluster     = cluster_i;
      res_o.attribute   = attribute_i;
      res_o.type_tag    = type_tag_i;
      res_o.value_centi = centi;
      res_o.value_flag  = flag;
      res_o.quality     = link_quality_i;
      res_o.battery     = batt;
    end
  end

endmodule

[verif/tb.sv]
// Self-checking testbench for the attribute report decoder: directed and random reports.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HalfPeriod = 10;
  // Slowest correct run: a random send gap plus a random result stall plus the decoder latency.
  localparam int WatchdogLimit = 1000;
  localparam int MaxReported = 10;

  localparam logic [15:0] ClTemperature = 16'h0402;
  localparam logic [15:0] ClHumidity = 16'h0405;
  localparam logic [15:0] ClCo2 = 16'h040D;
  localparam logic [15:0] ClBinaryInput = 16'h000F;
  localparam logic [15:0] AttrMeasured = 16'h0000;
  localparam logic [15:0] AttrPresentValue = 16'h0055;
  localparam logic [15:0] AttrBatteryRemaining = 16'h0021;

  typedef struct packed {
    logic [63:0] addr;
    logic [15:0] cl;
    logic [15:0] at;
    logic [7:0]  tag;
    logic [31:0] payload;
    logic [7:0]  len;
    logic [7:0]  lqi;
  } report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [63:0]        source_address_i = '0;
  logic [15:0]        cluster_i = '0;
  logic [15:0]        attribute_i = '0;
  logic [7:0]         type_tag_i = '0;
  logic [31:0]        payload_bytes_i = '0;
  logic [7:0]         payload_len_i = '0;
  logic [7:0]         link_quality_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic [63:0]        report_address_o;
  logic [15:0]        report_cluster_o;
  logic [15:0]        report_attribute_o;
  logic [7:0]         report_type_o;
  logic signed [19:0] value_centi_o;
  logic               value_flag_o;
  logic [7:0]         report_quality_o;
  logic [7:0]         battery_percent_o;

  zard_pkg::result_t decoded_pending[$];
  int mismatches = 0;
  int results_checked = 0;
  int ok_seen = 0;
  int unmapped_seen = 0;
  int invalid_seen = 0;
  int flagged_seen = 0;
  int reports_sent = 0;
  int floats_sent = 0;
  int quiet_cycles = 0;
  int gap_one_in = 0;
  int stall_one_in = 0;
  int stall_left = 0;
  logic ready_next;
  logic extremes_toggle = 1'b0;

  zcl_attribute_report_decoder dut (.*);

  always #HalfPeriod clk_i = ~clk_i;

  function automatic int unsigned tag_bytes(input logic [7:0] tag);
    case (tag)
      zard_pkg::TagBool, zard_pkg::TagU8, zard_pkg::TagS8: return 1;
      zard_pkg::TagU16, zard_pkg::TagS16: return 2;
      zard_pkg::TagU24: return 3;
      zard_pkg::TagU32, zard_pkg::TagS32, zard_pkg::TagF32: return 4;
      default: return 0;
    endcase
  endfunction

  // Round p / 2^s to nearest, ties away from zero (p is a magnitude).
  function automatic logic [63:0] round_half_up(input logic [63:0] p, input int unsigned s);
    logic [63:0] q;
    logic [63:0] rem;
    if (s == 0) return p;
    if (s >= 63) return '0;
    q = p >> s;
    rem = p & ((64'd1 << s) - 64'd1);
    if (rem >= (64'd1 << (s - 1))) q = q + 64'd1;
    return q;
  endfunction

  function automatic zard_pkg::result_t decode_report(input report_t rep);
    zard_pkg::result_t r;
    logic known, is_binary, battery_map;
    logic [63:0] neg_lim, pos_lim, mul, lim, mag, ip, centi_mag, pct;
    logic neg, huge, is_nan, frac;
    logic [7:0] ex;
    logic [22:0] fr;
    logic [19:0] centi20;
    int unsigned nbytes, sh;
    r = '0;
    known = 1'b1;
    is_binary = 1'b0;
    battery_map = 1'b0;
    neg_lim = '0;
    pos_lim = '0;
    mul = '0;
    case ({rep.cl, rep.at})
      {ClTemperature, AttrMeasured}: begin
        neg_lim = 64'd4000; pos_lim = 64'd8000; mul = 64'd1;
      end
      {ClHumidity, AttrMeasured}: begin
        pos_lim = 64'd10000; mul = 64'd1;
      end
      {ClCo2, AttrMeasured}: begin
        pos_lim = 64'd5000; mul = 64'd100;
      end
      {ClBinaryInput, AttrPresentValue}: is_binary = 1'b1;
      {zard_pkg::BatteryCluster, AttrBatteryRemaining}: begin
        battery_map = 1'b1; pos_lim = 64'd200; mul = 64'd50;
      end
      default: known = 1'b0;
    endcase
    if (!known) begin
      r.status = zard_pkg::StNotMapped;
      return r;
    end
    nbytes = tag_bytes(rep.tag);
    if (nbytes == 0 || {24'd0, rep.len} < nbytes) begin
      r.status = zard_pkg::StInvalid;
      return r;
    end

    neg = 1'b0;
    huge = 1'b0;
    is_nan = 1'b0;
    sh = 0;
    mag = '0;
    ex = '0;
    fr = '0;
    case (rep.tag)
      zard_pkg::TagBool, zard_pkg::TagU8: mag = 64'(rep.payload[7:0]);
      zard_pkg::TagU16: mag = 64'(rep.payload[15:0]);
      zard_pkg::TagU24: mag = 64'(rep.payload[23:0]);
      zard_pkg::TagU32: mag = 64'(rep.payload);
      zard_pkg::TagS8: begin
        neg = rep.payload[7];
        mag = neg ? 64'h100 - 64'(rep.payload[7:0]) : 64'(rep.payload[7:0]);
      end
      zard_pkg::TagS16: begin
        neg = rep.payload[15];
        mag = neg ? 64'h10000 - 64'(rep.payload[15:0]) : 64'(rep.payload[15:0]);
      end
      zard_pkg::TagS32: begin
        neg = rep.payload[31];
        mag = neg ? 64'h1_0000_0000 - 64'(rep.payload) : 64'(rep.payload);
      end
      default: begin
        // float32: value = mag / 2^sh
        neg = rep.payload[31];
        ex = rep.payload[30:23];
        fr = rep.payload[22:0];
        if (ex == 8'hFF) begin
          if (fr != '0) is_nan = 1'b1;
          else begin
            huge = 1'b1;
            mag = 64'd1;
          end
        end else if (ex == 8'h00) begin
          mag = 64'(fr);
          sh = 149;
        end else begin
          mag = 64'({1'b1, fr});
          if (ex >= 8'd150) huge = 1'b1;
          else sh = 150 - 32'(ex);
        end
      end
    endcase
    if (is_nan) begin
      r.status = zard_pkg::StInvalid;
      return r;
    end

    r.battery = 8'hFF;
    if (is_binary) begin
      if (huge || mag != '0) begin
        r.value_flag = 1'b1;
        r.value_centi = 20'sd100;
      end
    end else begin
      if (huge) begin
        r = '0;
        r.status = zard_pkg::StInvalid;
        return r;
      end
      lim = neg ? neg_lim : pos_lim;
      if (sh >= 64) begin
        ip = '0;
        frac = (mag != '0);
      end else begin
        ip = mag >> sh;
        frac = (mag & ((64'd1 << sh) - 64'd1)) != '0;
      end
      if (ip > lim || (ip == lim && frac)) begin
        r = '0;
        r.status = zard_pkg::StInvalid;
        return r;
      end
      centi_mag = round_half_up(mag * mul, sh);
      centi20 = centi_mag[19:0];
      if (neg) centi20 = 20'd0 - centi20;
      r.value_centi = centi20;
      if (battery_map) begin
        pct = round_half_up(mag, sh + 1);
        r.battery = pct[7:0];
      end
    end
    r.status = zard_pkg::StOk;
    r.address = rep.addr;
    r.cluster = rep.cl;
    r.attribute = rep.at;
    r.type_tag = rep.tag;
    r.quality = rep.lqi;
    return r;
  endfunction

  // Random report; noise_pct of fields are unconstrained, at least float_pct of tags are float32.
  function automatic report_t random_report(input int noise_pct, input int float_pct);
    report_t rep;
    int unsigned idx, w, k;
    int lo, hi, v;
    logic [31:0] width_mask;
    logic [22:0] fr;
    logic [7:0] ex;
    rep.addr = {$urandom, $urandom};
    rep.lqi = 8'($urandom_range(0, 255));
    idx = $urandom_range(0, 4);
    lo = 0;
    case (idx)
      0: begin rep.cl = ClTemperature; rep.at = AttrMeasured; lo = 4000; hi = 8000; end
      1: begin rep.cl = ClHumidity; rep.at = AttrMeasured; hi = 10000; end
      2: begin rep.cl = ClCo2; rep.at = AttrMeasured; hi = 5000; end
      3: begin rep.cl = ClBinaryInput; rep.at = AttrPresentValue; hi = 2; end
      default: begin
        rep.cl = zard_pkg::BatteryCluster; rep.at = AttrBatteryRemaining; hi = 200;
      end
    endcase
    if ($urandom_range(0, 99) < noise_pct) begin
      rep.at = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 1) == 0) rep.cl = 16'($urandom_range(0, 65535));
    end

    if ($urandom_range(0, 99) < float_pct) rep.tag = zard_pkg::TagF32;
    else if ($urandom_range(0, 99) < noise_pct) rep.tag = 8'($urandom_range(0, 255));
    else begin
      case ($urandom_range(0, 8))
        0: rep.tag = zard_pkg::TagBool;
        1: rep.tag = zard_pkg::TagU8;
        2: rep.tag = zard_pkg::TagU16;
        3: rep.tag = zard_pkg::TagU24;
        4: rep.tag = zard_pkg::TagU32;
        5: rep.tag = zard_pkg::TagS8;
        6: rep.tag = zard_pkg::TagS16;
        7: rep.tag = zard_pkg::TagS32;
        default: rep.tag = zard_pkg::TagF32;
      endcase
    end

    w = tag_bytes(rep.tag);
    if (w == 0 || $urandom_range(0, 99) < noise_pct) rep.len = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 7) == 0) rep.len = 8'($urandom_range(w, 255));
    else rep.len = 8'($urandom_range(w, 4));

    if (rep.tag == zard_pkg::TagF32) begin
      k = $urandom_range(0, 23);
      // clear low fraction bits so exact halves come up often
      fr = 23'($urandom) & ~((23'd1 << k) - 23'd1);
      case ($urandom_range(0, 19))
        0: begin
          ex = 8'hFF;
          if ($urandom_range(0, 1) == 0) fr = '0;
        end
        1: ex = 8'h00;
        2: ex = 8'($urandom_range(0, 255));
        default: ex = 8'($urandom_range(118, 142));
      endcase
      rep.payload = {1'($urandom_range(0, 1)), ex, fr};
    end else if ($urandom_range(0, 99) < noise_pct) begin
      rep.payload = $urandom;
    end else begin
      if ($urandom_range(0, 4) == 0)
        v = ($urandom_range(0, 1) == 0 ? hi : -lo) + int'($urandom_range(0, 4)) - 2;
      else
        v = int'($urandom_range(0, hi + lo + 10)) - lo - 5;
      rep.payload = 32'(v);
      if (w != 0 && $urandom_range(0, 1) == 0) begin
        width_mask = (w >= 4) ? '1 : (32'd1 << (8 * w)) - 32'd1;
        rep.payload = (rep.payload & width_mask) | ($urandom & ~width_mask);
      end
    end
    return rep;
  endfunction

  // Hold the request until accepted, then record its decode.
  task automatic send_report(input report_t rep);
    in_valid_i <= 1'b1;
    source_address_i <= rep.addr;
    cluster_i <= rep.cl;
    attribute_i <= rep.at;
    type_tag_i <= rep.tag;
    payload_bytes_i <= rep.payload;
    payload_len_i <= rep.len;
    link_quality_i <= rep.lqi;
    do @(posedge clk_i); while (!in_ready_o);
    decoded_pending.push_back(decode_report(rep));
    reports_sent++;
    if (rep.tag == zard_pkg::TagF32) floats_sent++;
  endtask

  task automatic send_fixed(input logic [15:0] cl, input logic [15:0] at,
                            input logic [7:0] tag, input logic [31:0] payload,
                            input logic [7:0] len);
    report_t rep;
    extremes_toggle = ~extremes_toggle;
    rep.addr = extremes_toggle ? '1 : '0;
    rep.lqi = extremes_toggle ? '1 : '0;
    rep.cl = cl;
    rep.at = at;
    rep.tag = tag;
    rep.payload = payload;
    rep.len = len;
    send_report(rep);
  endtask

  task automatic maybe_gap();
    if (gap_one_in != 0 && $urandom_range(1, gap_one_in) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decoded_pending.size() != 0);
  endtask

  task automatic send_random(input int count, input int noise_pct, input int float_pct);
    repeat (count) begin
      send_report(random_report(noise_pct, float_pct));
      maybe_gap();
    end
  endtask

  task automatic test_mapping_limits();
    gap_one_in = 4;
    stall_one_in = 5;
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagS16, 32'h0000_F060, 8'd2);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagS16, 32'h0000_F05F, 8'd2);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagS16, 32'h0000_1F40, 8'd2);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagS16, 32'h0000_1F41, 8'd2);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagS8, 32'h0000_0080, 8'd1);
    send_fixed(ClHumidity, AttrMeasured, zard_pkg::TagU16, 32'h0000_2710, 8'd2);
    send_fixed(ClHumidity, AttrMeasured, zard_pkg::TagU16, 32'h0000_2711, 8'd2);
    send_fixed(ClCo2, AttrMeasured, zard_pkg::TagU16, 32'h0000_1388, 8'd2);
    send_fixed(ClCo2, AttrMeasured, zard_pkg::TagS32, 32'hFFFF_FFFF, 8'd4);
    send_fixed(zard_pkg::BatteryCluster, AttrBatteryRemaining, zard_pkg::TagU8,
               32'h0000_00C8, 8'd1);
    send_fixed(zard_pkg::BatteryCluster, AttrBatteryRemaining, zard_pkg::TagU8,
               32'h0000_00C9, 8'd1);
    send_fixed(zard_pkg::BatteryCluster, AttrBatteryRemaining, zard_pkg::TagU8,
               32'h0000_0001, 8'd1);
    send_fixed(ClBinaryInput, AttrPresentValue, zard_pkg::TagBool, 32'h0000_0000, 8'd1);
    send_fixed(ClBinaryInput, AttrPresentValue, zard_pkg::TagBool, 32'h0000_00FF, 8'd1);
    // upper byte lies beyond the 24-bit width
    send_fixed(ClBinaryInput, AttrPresentValue, zard_pkg::TagU24, 32'hAA00_0000, 8'd4);
    wait_for_results();
  endtask

  task automatic test_special_cases();
    send_fixed(ClTemperature, 16'h0001, zard_pkg::TagS16, 32'h0000_0001, 8'd2);
    send_fixed(ClHumidity, AttrMeasured, 8'h30, 32'h0000_0001, 8'd4);
    send_fixed(ClHumidity, AttrMeasured, zard_pkg::TagU16, 32'h0000_0001, 8'd1);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagF32, 32'h7FC0_0000, 8'd4);
    send_fixed(ClBinaryInput, AttrPresentValue, zard_pkg::TagF32, 32'hFFFF_FFFF, 8'd4);
    send_fixed(ClBinaryInput, AttrPresentValue, zard_pkg::TagF32, 32'h7F80_0000, 8'd4);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagF32, 32'hFF80_0000, 8'd4);
    send_fixed(ClHumidity, AttrMeasured, zard_pkg::TagF32, 32'h8000_0000, 8'd4);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagF32, 32'h41CC_0000, 8'd4);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagF32, 32'h0000_0001, 8'd4);
    send_fixed(ClTemperature, AttrMeasured, zard_pkg::TagF32, 32'hBF00_0000, 8'd4);
    wait_for_results();
  endtask

  task automatic test_mapped_reports();
    gap_one_in = 5;
    stall_one_in = 6;
    send_random(300, 10, 10);
    // hold off new requests until the decoder has drained
    wait_for_results();
  endtask

  task automatic test_noisy_reports();
    gap_one_in = 3;
    stall_one_in = 3;
    send_random(220, 40, 15);
    wait_for_results();
  endtask

  task automatic test_float_reports();
    gap_one_in = 8;
    stall_one_in = 10;
    send_random(160, 10, 70);
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    gap_one_in = 0;
    stall_one_in = 0;
    send_random(200, 15, 15);
    wait_for_results();
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) note_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  task automatic check_result();
    zard_pkg::result_t want;
    if (decoded_pending.size() == 0) begin
      note_mismatch($sformatf("result with no request pending, status %0d", status_o));
      return;
    end
    want = decoded_pending.pop_front();
    results_checked++;
    case (want.status)
      zard_pkg::StOk: ok_seen++;
      zard_pkg::StNotMapped: unmapped_seen++;
      default: invalid_seen++;
    endcase
    if (want.value_flag) flagged_seen++;
    check_field("status", 64'(want.status), 64'(status_o));
    check_field("report_address", want.address, report_address_o);
    check_field("report_cluster", 64'(want.cluster), 64'(report_cluster_o));
    check_field("report_attribute", 64'(want.attribute), 64'(report_attribute_o));
    check_field("report_type", 64'(want.type_tag), 64'(report_type_o));
    check_field("value_centi", 64'(want.value_centi), 64'(value_centi_o));
    check_field("value_flag", 64'(want.value_flag), 64'(value_flag_o));
    check_field("report_quality", 64'(want.quality), 64'(report_quality_o));
    check_field("battery_percent", 64'(want.battery), 64'(battery_percent_o));
  endtask

  // Check accepted results and drive out_ready_i with random stall bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result();
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (stall_one_in != 0 && $urandom_range(1, stall_one_in) == 1) begin
        stall_left = $urandom_range(1, 18) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready_i <= ready_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: nothing moved for %0d cycles", WatchdogLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_mapping_limits();
    test_special_cases();
    test_mapped_reports();
    test_noisy_reports();
    test_float_reports();
    test_back_to_back();
    repeat (8) @(posedge clk_i);
    if (decoded_pending.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", decoded_pending.size()));
    $display("decoded %0d reports (%0d float32), checked %0d results", reports_sent,
             floats_sent, results_checked);
    $display("status mix: %0d ok, %0d unmapped, %0d invalid; %0d binary inputs active",
             ok_seen, unmapped_seen, invalid_seen, flagged_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
